// ===== hdl/rss_pkg.sv =====
package rss_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int TIME_W      = 63;
  localparam int HASH_W      = 32;
  localparam int STEP_W      = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_HASH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_HASH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SOURCES = 2'd2;

  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_SET    = 1'b1;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_stat_t;

endpackage

// ===== hdl/ready_source_selector.sv =====
// Server selector with per-server suspension times. A set request (req_type 1)
// writes one suspension time and returns an all-zero result through S_FIN.
// A select request scans the configured servers, at most 16, one per cycle
// through a single 63-bit time comparator, reduces the round robin pointer or
// the magnitude of the host hash modulo the candidate count in a one-bit-per-
// cycle remainder unit (5 steps in round robin mode, 32 in hash mode), then
// walks the captured ready mask one server per cycle to the chosen member.
// With num_sources 0 the request goes straight to S_FIN and returns the empty
// result. One request is in flight at a time; in_ready is high only while the
// sequencer is idle. The result sits in an output register until out_ready
// takes it. Configuration is to be written with cfg_we, cfg_index and
// cfg_wdata only while no request is in flight; the block itself does not
// enforce this.
module ready_source_selector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rss_pkg::HASH_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [rss_pkg::IDX_W-1:0]         in_entry,
  input  logic [rss_pkg::TIME_W-1:0]        in_suspend_until,
  input  logic [rss_pkg::TIME_W-1:0]        in_now,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [rss_pkg::IDX_W-1:0]         out_source_index,
  output logic                              out_from_suspended
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV_START, S_DIV, S_PICK, S_FIN} state_t;

  state_t                          state_r;
  logic                            use_hash_r;
  logic [rss_pkg::HASH_W-1:0]      host_hash_r;
  logic [rss_pkg::CNT_W-1:0]       num_sources_r;
  logic [rss_pkg::CNT_W-1:0]       rr_pointer_r;
  logic [rss_pkg::TIME_W-1:0]      now_r;
  logic [rss_pkg::IDX_W-1:0]       idx_r;
  logic [rss_pkg::IDX_W-1:0]       last_r;
  logic [rss_pkg::MAX_SOURCES-1:0] mask_r;
  logic [rss_pkg::CNT_W-1:0]       ready_cnt_r;
  logic [rss_pkg::CNT_W-1:0]       cand_cnt_r;
  logic                            want_ready_r;
  logic [rss_pkg::IDX_W-1:0]       sel_r;
  logic [rss_pkg::IDX_W-1:0]       k_r;
  logic                            res_found_r;
  logic [rss_pkg::IDX_W-1:0]       res_idx_r;
  logic                            res_susp_r;
  logic                            out_valid_r;
  logic                            out_found_r;
  logic [rss_pkg::IDX_W-1:0]       out_index_r;
  logic                            out_susp_r;

  logic                            in_fire;
  logic                            is_ready;
  logic [rss_pkg::CNT_W-1:0]       n_eff;
  logic [rss_pkg::CNT_W-1:0]       ready_cnt_nxt;
  logic [rss_pkg::CNT_W-1:0]       cand_cnt_nxt;
  logic [rss_pkg::HASH_W-1:0]      hash_mag;
  rss_pkg::div_ctrl_t              div_ctrl;
  rss_pkg::div_stat_t              div_stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign n_eff = (num_sources_r > rss_pkg::CNT_W'(rss_pkg::MAX_SOURCES)) ?
                 rss_pkg::CNT_W'(rss_pkg::MAX_SOURCES) : num_sources_r;

  assign ready_cnt_nxt = ready_cnt_r + rss_pkg::CNT_W'(is_ready);
  assign cand_cnt_nxt  = (ready_cnt_nxt != '0) ? ready_cnt_nxt
                                               : {1'b0, last_r} + 1'b1 - ready_cnt_nxt;

  assign hash_mag = host_hash_r[rss_pkg::HASH_W-1] ? (~host_hash_r + 1'b1) : host_hash_r;

  always_comb begin
    div_ctrl.start   = (state_r == S_DIV_START);
    div_ctrl.divisor = cand_cnt_r;
    if (use_hash_r) begin
      div_ctrl.dividend = hash_mag;
      div_ctrl.steps    = rss_pkg::STEP_W'(rss_pkg::HASH_W);
    end else begin
      div_ctrl.dividend = {rr_pointer_r, {(rss_pkg::HASH_W - rss_pkg::CNT_W){1'b0}}};
      div_ctrl.steps    = rss_pkg::STEP_W'(rss_pkg::CNT_W);
    end
  end

  rss_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_fire && in_req_type == rss_pkg::REQ_SET),
    .wr_addr  (in_entry),
    .wr_data  (in_suspend_until),
    .rd_addr  (idx_r),
    .now      (now_r),
    .is_ready (is_ready)
  );

  rss_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_hash_r    <= 1'b0;
      host_hash_r   <= '0;
      num_sources_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rss_pkg::CFG_USE_HASH:    use_hash_r    <= cfg_wdata[0];
        rss_pkg::CFG_HOST_HASH:   host_hash_r   <= cfg_wdata;
        rss_pkg::CFG_NUM_SOURCES: num_sources_r <= cfg_wdata[rss_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rr_pointer_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            now_r       <= in_now;
            idx_r       <= '0;
            last_r      <= rss_pkg::IDX_W'(n_eff - 1'b1);
            ready_cnt_r <= '0;
            res_found_r <= 1'b0;
            res_idx_r   <= '0;
            res_susp_r  <= 1'b0;
            if (in_req_type == rss_pkg::REQ_SET || n_eff == '0) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          mask_r[idx_r] <= is_ready;
          ready_cnt_r   <= ready_cnt_nxt;
          idx_r         <= idx_r + 1'b1;
          if (idx_r == last_r) begin
            want_ready_r <= (ready_cnt_nxt != '0);
            cand_cnt_r   <= cand_cnt_nxt;
            state_r      <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            sel_r   <= div_stat.rem;
            idx_r   <= '0;
            k_r     <= '0;
            state_r <= S_PICK;
            if (!use_hash_r) begin
              rr_pointer_r <= rss_pkg::CNT_W'(div_stat.rem) + 1'b1;
            end
          end
        end
        S_PICK: begin
          idx_r <= idx_r + 1'b1;
          if (mask_r[idx_r] == want_ready_r) begin
            k_r <= k_r + 1'b1;
            if (k_r == sel_r) begin
              res_found_r <= 1'b1;
              res_idx_r   <= idx_r;
              res_susp_r  <= !want_ready_r;
              state_r     <= S_FIN;
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_index_r <= res_idx_r;
            out_susp_r  <= res_susp_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_source_index   = out_index_r;
  assign out_from_suspended = out_susp_r;

endmodule

// ===== hdl/rss_store.sv =====
module rss_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [rss_pkg::IDX_W-1:0]    wr_addr,
  input  logic [rss_pkg::TIME_W-1:0]   wr_data,
  input  logic [rss_pkg::IDX_W-1:0]    rd_addr,
  input  logic [rss_pkg::TIME_W-1:0]   now,
  output logic                         is_ready
);

  logic [rss_pkg::TIME_W-1:0]      mem_r [rss_pkg::MAX_SOURCES];
  logic [rss_pkg::MAX_SOURCES-1:0] valid_r;
  logic [rss_pkg::TIME_W-1:0]      rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // unwritten entries hold time zero
  assign rd_data  = valid_r[rd_addr] ? mem_r[rd_addr] : '0;
  assign is_ready = rd_data < now;

endmodule

// ===== hdl/rss_divider.sv =====
module rss_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  rss_pkg::div_ctrl_t ctrl,
  output rss_pkg::div_stat_t stat
);

  logic                              busy_r;
  logic                              done_r;
  logic [rss_pkg::STEP_W-1:0]        steps_r;
  logic [rss_pkg::HASH_W-1:0]        dvd_r;
  logic [rss_pkg::CNT_W-1:0]         dvs_r;
  logic [rss_pkg::CNT_W-1:0]         rem_r;
  logic [rss_pkg::CNT_W-1:0]         shifted;
  logic [rss_pkg::CNT_W-1:0]         rem_nxt;

  // partial remainder stays below the divisor, so four bits carry it
  assign shifted = {rem_r[rss_pkg::CNT_W-2:0], dvd_r[rss_pkg::HASH_W-1]};
  assign rem_nxt = (shifted >= dvs_r) ? shifted - dvs_r : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && steps_r == rss_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd_r   <= ctrl.dividend;
      dvs_r   <= ctrl.divisor;
      steps_r <= ctrl.steps;
      rem_r   <= '0;
    end else if (busy_r) begin
      dvd_r   <= {dvd_r[rss_pkg::HASH_W-2:0], 1'b0};
      steps_r <= steps_r - rss_pkg::STEP_W'(1);
      rem_r   <= rem_nxt;
    end
  end

  assign stat.done = done_r;
  assign stat.rem  = rem_r[rss_pkg::IDX_W-1:0];

endmodule
